@@ rtl/hpd_pkg.sv @@
// ----------------------------------------------------------------------------
// hpd_pkg: shared definitions for the haptics packet deframer
// Header layout, status codes, result kinds, register indices and the result word layout.
// ----------------------------------------------------------------------------
package hpd_pkg;

  localparam int HDR_BYTES = 32;
  localparam int MAX_FRAMES_DEF = 64;
  localparam int CHANNELS_DEF = 2;

  // Byte offsets of the header fields.
  localparam int OFS_VERSION = 4;
  localparam int OFS_STREAM = 8;
  localparam int OFS_SEQUENCE = 12;
  localparam int OFS_TIMESTAMP = 20;
  localparam int OFS_FRAMES = 28;
  localparam int OFS_RESERVED = 30;

  typedef enum logic [3:0] {
    STAT_OK        = 4'd0,
    STAT_LENGTH    = 4'd1,
    STAT_MAGIC     = 4'd2,
    STAT_RESERVED  = 4'd3,
    STAT_COUNT     = 4'd4,
    STAT_VERSION   = 4'd5,
    STAT_ZERO_ID   = 4'd6,
    STAT_FRAMES    = 4'd7,
    STAT_NONFINITE = 4'd8
  } status_t;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam logic CFG_MAGIC = 1'b0;
  localparam logic CFG_VERSION = 1'b1;

  typedef struct packed {
    logic        item_kind;
    logic [31:0] sample_bits;
    logic [6:0]  sample_index;
    logic [3:0]  status;
    logic [31:0] stream_ident;
    logic [63:0] sequence_res;
    logic [63:0] timestamp_ns;
    logic [15:0] frame_total;
  } result_t;

endpackage

@@ rtl/haptics_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// haptics_packet_deframer: byte-stream deframer for haptics sample packets
// Collects a 32-byte header, emits each 4-byte sample word and ends every
// packet with a status word carrying the header fields.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) moves one packet byte per word,
//   with last_byte set on the final byte. The output channel (out_valid /
//   out_stall) moves result words: sample words (item_kind 0) and one end
//   word (item_kind 1) per packet, carrying the status and header fields.
//   Consumers discard a packet's samples when its end status is nonzero.
//   magic_word and expected_version are to be written through cfg_write only
//   while the block is idle; the block itself does not enforce this.
//   Each result is registered in the output queue before it reaches the output.
//   Throughput is one byte per cycle while in_stall is low; each byte needs
//   only a position compare and a register load. A final byte that also
//   completes a sample pushes two words into the four-entry output queue,
//   which then drains one word per cycle while out_stall is low.
//   in_stall rises while the queue holds more than two words, so a stalled
//   receiver backs up into the byte stream without loss.
//   Reset empties the queue, clears the packet state and restores the
//   registers to magic 0 and version 1.
// ----------------------------------------------------------------------------
module haptics_packet_deframer
  import hpd_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        item_kind,
  output logic [31:0] sample_bits,
  output logic [6:0]  sample_index,
  output logic [3:0]  status,
  output logic [31:0] stream_ident,
  output logic [63:0] sequence_res,
  output logic [63:0] timestamp_ns,
  output logic [15:0] frame_total
);

  localparam int MaxBytes = HDR_BYTES + MAX_FRAMES * CHANNELS * 4;
  localparam int POS_W = $clog2(MaxBytes + 2);
  localparam int REL_W = (POS_W > 9) ? POS_W : 9;
  localparam int EXP_W = 16 + $clog2(CHANNELS * 4 + 1) + 1;
  localparam int CMP_W = (EXP_W > POS_W) ? EXP_W : POS_W;
  localparam int QDEPTH = 4;
  localparam int QA_W = $clog2(QDEPTH);
  localparam int QC_W = $clog2(QDEPTH + 1);

  logic [31:0] magic_word;
  logic [31:0] expected_version;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [31:0] header_magic, header_magic_next;
  logic [31:0] header_version, header_version_next;
  logic [31:0] header_stream, header_stream_next;
  logic [63:0] header_sequence, header_sequence_next;
  logic [63:0] header_timestamp, header_timestamp_next;
  logic [15:0] header_frames, header_frames_next;
  logic [15:0] reserved_word, reserved_word_next;
  logic [31:0] word_assembly, word_assembly_next;
  logic        nonfinite_seen, nonfinite_seen_next;

  result_t          queue [QDEPTH];
  logic [QA_W-1:0]  head, tail;
  logic [QC_W-1:0]  count;

  logic             in_acc, out_acc;
  logic             sample_fire;
  logic [31:0]      sample_word;
  logic [REL_W-1:0] rel;
  logic [2:0]       seq_lane, ts_lane;
  logic [CMP_W-1:0] len_ext, expect_ext;
  status_t          stat;
  result_t          sample_res, end_res;
  logic [1:0]       push_n;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = count > QC_W'(2);
  assign out_valid = count != '0;

  assign rel = REL_W'(byte_position) - REL_W'(HDR_BYTES);
  assign seq_lane = 3'(byte_position[4:0] - 5'(OFS_SEQUENCE));
  assign ts_lane = 3'(byte_position[4:0] - 5'(OFS_TIMESTAMP));

  always_comb begin
    byte_position_next = byte_position;
    header_magic_next = header_magic;
    header_version_next = header_version;
    header_stream_next = header_stream;
    header_sequence_next = header_sequence;
    header_timestamp_next = header_timestamp;
    header_frames_next = header_frames;
    reserved_word_next = reserved_word;
    word_assembly_next = word_assembly;
    nonfinite_seen_next = nonfinite_seen;
    sample_fire = 1'b0;
    sample_word = {data_byte, word_assembly[23:0]};

    if (byte_position < POS_W'(OFS_VERSION)) begin
      header_magic_next[8*byte_position[1:0] +: 8] = data_byte;
    end else if (byte_position < POS_W'(OFS_STREAM)) begin
      header_version_next[8*byte_position[1:0] +: 8] = data_byte;
    end else if (byte_position < POS_W'(OFS_SEQUENCE)) begin
      header_stream_next[8*byte_position[1:0] +: 8] = data_byte;
    end else if (byte_position < POS_W'(OFS_TIMESTAMP)) begin
      header_sequence_next[8*seq_lane +: 8] = data_byte;
    end else if (byte_position < POS_W'(OFS_FRAMES)) begin
      header_timestamp_next[8*ts_lane +: 8] = data_byte;
    end else if (byte_position < POS_W'(OFS_RESERVED)) begin
      header_frames_next[8*byte_position[0] +: 8] = data_byte;
    end else if (byte_position < POS_W'(HDR_BYTES)) begin
      reserved_word_next[8*byte_position[0] +: 8] = data_byte;
    end else if (byte_position < POS_W'(MaxBytes)) begin
      // The header is a multiple of four bytes, so the low position bits
      // give the byte lane within the sample word.
      word_assembly_next[8*byte_position[1:0] +: 8] = data_byte;
      if (byte_position[1:0] == 2'd3) begin
        sample_fire = 1'b1;
        word_assembly_next = '0;
        if (sample_word[30:23] == 8'hFF) begin
          nonfinite_seen_next = 1'b1;
        end
      end
    end

    if (byte_position <= POS_W'(MaxBytes)) begin
      byte_position_next = byte_position + POS_W'(1);
    end

    len_ext = CMP_W'(byte_position_next);
    expect_ext = CMP_W'(HDR_BYTES) + CMP_W'(header_frames_next) * CMP_W'(CHANNELS * 4);

    if (len_ext < CMP_W'(HDR_BYTES) || len_ext > CMP_W'(MaxBytes)) begin
      stat = STAT_LENGTH;
    end else if (header_magic_next != magic_word) begin
      stat = STAT_MAGIC;
    end else if (reserved_word_next != '0) begin
      stat = STAT_RESERVED;
    end else if (len_ext != expect_ext) begin
      stat = STAT_COUNT;
    end else if (header_version_next != expected_version) begin
      stat = STAT_VERSION;
    end else if (header_stream_next == '0) begin
      stat = STAT_ZERO_ID;
    end else if (header_frames_next == '0 || header_frames_next > 16'(MAX_FRAMES)) begin
      stat = STAT_FRAMES;
    end else if (nonfinite_seen_next) begin
      stat = STAT_NONFINITE;
    end else begin
      stat = STAT_OK;
    end

    sample_res = '0;
    sample_res.item_kind = KIND_SAMPLE;
    sample_res.sample_bits = sample_word;
    sample_res.sample_index = rel[8:2];

    end_res = '0;
    end_res.item_kind = KIND_END;
    end_res.status = stat;
    end_res.stream_ident = header_stream_next;
    end_res.sequence_res = header_sequence_next;
    end_res.timestamp_ns = header_timestamp_next;
    end_res.frame_total = header_frames_next;

    push_n = 2'({1'b0, sample_fire} + {1'b0, last_byte});

    // The end word uses the header including this byte; then the packet
    // state starts over.
    if (last_byte) begin
      byte_position_next = '0;
      header_magic_next = '0;
      header_version_next = '0;
      header_stream_next = '0;
      header_sequence_next = '0;
      header_timestamp_next = '0;
      header_frames_next = '0;
      reserved_word_next = '0;
      word_assembly_next = '0;
      nonfinite_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= '0;
      expected_version <= 32'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAGIC:   magic_word <= cfg_data;
        CFG_VERSION: expected_version <= cfg_data;
        default:     magic_word <= magic_word;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      header_magic <= '0;
      header_version <= '0;
      header_stream <= '0;
      header_sequence <= '0;
      header_timestamp <= '0;
      header_frames <= '0;
      reserved_word <= '0;
      word_assembly <= '0;
      nonfinite_seen <= 1'b0;
    end else if (in_acc) begin
      byte_position <= byte_position_next;
      header_magic <= header_magic_next;
      header_version <= header_version_next;
      header_stream <= header_stream_next;
      header_sequence <= header_sequence_next;
      header_timestamp <= header_timestamp_next;
      header_frames <= header_frames_next;
      reserved_word <= reserved_word_next;
      word_assembly <= word_assembly_next;
      nonfinite_seen <= nonfinite_seen_next;
    end
  end

  // Output queue: up to two words enter per byte, one word leaves per cycle while out_stall is low.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (sample_fire) begin
        queue[tail] <= sample_res;
        if (last_byte) begin
          queue[tail + QA_W'(1)] <= end_res;
        end
      end else if (last_byte) begin
        queue[tail] <= end_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (in_acc) begin
        tail <= tail + QA_W'(push_n);
      end
      if (out_acc) begin
        head <= head + QA_W'(1);
      end
      count <= count + (in_acc ? QC_W'(push_n) : '0) - (out_acc ? QC_W'(1) : '0);
    end
  end

  assign item_kind = queue[head].item_kind;
  assign sample_bits = queue[head].sample_bits;
  assign sample_index = queue[head].sample_index;
  assign status = queue[head].status;
  assign stream_ident = queue[head].stream_ident;
  assign sequence_res = queue[head].sequence_res;
  assign timestamp_ns = queue[head].timestamp_ns;
  assign frame_total = queue[head].frame_total;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(QDEPTH))
    else $error("output queue count exceeds its depth");

  a_end_queued: assert property (@(posedge clk) disable iff (rst)
    in_acc && last_byte |=> count != '0)
    else $error("final byte accepted but no end word queued");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && last_byte |=> byte_position == '0 && !nonfinite_seen)
    else $error("packet state not cleared after final byte");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_W'(MaxBytes + 1))
    else $error("byte position beyond saturation value");

  a_nonfinite_payload: assert property (@(posedge clk) disable iff (rst)
    nonfinite_seen |-> byte_position > POS_W'(HDR_BYTES))
    else $error("nonfinite flag set while still in header");

endmodule

@@ dv/hpd_checker.sv @@
// ----------------------------------------------------------------------------
// hpd_checker: result predictor and scoreboard for the packet deframer
// Watches the register port and both channels, predicts the sample and end
// words of every accepted byte, and compares each delivered word in order.
// ----------------------------------------------------------------------------
module hpd_checker
  import hpd_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        item_kind,
  input  logic [31:0] sample_bits,
  input  logic [6:0]  sample_index,
  input  logic [3:0]  status,
  input  logic [31:0] stream_ident,
  input  logic [63:0] sequence_res,
  input  logic [63:0] timestamp_ns,
  input  logic [15:0] frame_total,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BYTES = HDR_BYTES + MAX_FRAMES * CHANNELS * 4;
  localparam int MAX_REPORTS = 100;
  localparam int EXP_DEPTH = 16;
  localparam int EXP_AW = $clog2(EXP_DEPTH);

  // Register copies as the block should hold them.
  logic [31:0] want_magic;
  logic [31:0] want_version;

  // Packet being collected.
  int unsigned byte_count;
  logic [31:0] hdr_magic;
  logic [31:0] hdr_version;
  logic [31:0] hdr_stream;
  logic [63:0] hdr_seq;
  logic [63:0] hdr_ts;
  logic [15:0] hdr_frames;
  logic [15:0] hdr_reserved;
  logic [31:0] word_acc;
  bit          saw_nonfinite;

  // Predicted words waiting for delivery, oldest at exp_head.
  result_t           exp_words [EXP_DEPTH];
  logic [EXP_AW-1:0] exp_head = '0;
  logic [EXP_AW-1:0] exp_tail = '0;
  int                exp_count = 0;
  int                errors = 0;

  task automatic clear_packet();
    byte_count = 0;
    hdr_magic = '0;
    hdr_version = '0;
    hdr_stream = '0;
    hdr_seq = '0;
    hdr_ts = '0;
    hdr_frames = '0;
    hdr_reserved = '0;
    word_acc = '0;
    saw_nonfinite = 0;
  endtask

  task automatic add_expected(input result_t w);
    exp_words[exp_tail] = w;
    exp_tail = exp_tail + 1'b1;
    exp_count++;
  endtask

  function automatic status_t packet_status(int unsigned len);
    int unsigned need;
    need = HDR_BYTES + hdr_frames * CHANNELS * 4;
    if (len < HDR_BYTES || len > MAX_BYTES) return STAT_LENGTH;
    if (hdr_magic != want_magic) return STAT_MAGIC;
    if (hdr_reserved != '0) return STAT_RESERVED;
    if (len != need) return STAT_COUNT;
    if (hdr_version != want_version) return STAT_VERSION;
    if (hdr_stream == '0) return STAT_ZERO_ID;
    if (hdr_frames == '0 || hdr_frames > MAX_FRAMES) return STAT_FRAMES;
    if (saw_nonfinite) return STAT_NONFINITE;
    return STAT_OK;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic fin);
    int unsigned pos;
    int unsigned rel;
    result_t w;
    pos = byte_count;
    if (pos < HDR_BYTES) begin
      if (pos < OFS_VERSION) hdr_magic[8*pos +: 8] = b;
      else if (pos < OFS_STREAM) hdr_version[8*(pos-OFS_VERSION) +: 8] = b;
      else if (pos < OFS_SEQUENCE) hdr_stream[8*(pos-OFS_STREAM) +: 8] = b;
      else if (pos < OFS_TIMESTAMP) hdr_seq[8*(pos-OFS_SEQUENCE) +: 8] = b;
      else if (pos < OFS_FRAMES) hdr_ts[8*(pos-OFS_TIMESTAMP) +: 8] = b;
      else if (pos < OFS_RESERVED) hdr_frames[8*(pos-OFS_FRAMES) +: 8] = b;
      else hdr_reserved[8*(pos-OFS_RESERVED) +: 8] = b;
    end else if (pos < MAX_BYTES) begin
      rel = pos - HDR_BYTES;
      word_acc[8*(rel % 4) +: 8] = b;
      if (rel % 4 == 3) begin
        // An all-ones exponent marks an infinity or a NaN.
        if (word_acc[30:23] == 8'hFF) saw_nonfinite = 1;
        w = '0;
        w.item_kind = KIND_SAMPLE;
        w.sample_bits = word_acc;
        w.sample_index = 7'(rel >> 2);
        add_expected(w);
        word_acc = '0;
      end
    end
    // The count stops one past the longest legal packet.
    if (pos <= MAX_BYTES) byte_count = pos + 1;
    if (fin) begin
      w = '0;
      w.item_kind = KIND_END;
      w.status = packet_status(byte_count);
      w.stream_ident = hdr_stream;
      w.sequence_res = hdr_seq;
      w.timestamp_ns = hdr_ts;
      w.frame_total = hdr_frames;
      add_expected(w);
      clear_packet();
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] hpd_checker: mismatch:%s", $time, what);
  endtask

  function automatic string field_diff(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) return $sformatf(" %s=%0h (exp %0h)", name, got, want);
    return "";
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    string   msg;
    if (rst) begin
      clear_packet();
      want_magic = '0;
      want_version = 32'd1;
      exp_head = '0;
      exp_tail = '0;
      exp_count = 0;
    end else begin
      // Outputs first: a word delivered now was caused by an earlier byte.
      if (out_valid && !out_stall) begin
        got.item_kind = item_kind;
        got.sample_bits = sample_bits;
        got.sample_index = sample_index;
        got.status = status;
        got.stream_ident = stream_ident;
        got.sequence_res = sequence_res;
        got.timestamp_ns = timestamp_ns;
        got.frame_total = frame_total;
        if (exp_count == 0) begin
          report_mismatch(" result word with nothing expected");
        end else begin
          want = exp_words[exp_head];
          exp_head = exp_head + 1'b1;
          exp_count--;
          msg = {field_diff("item_kind", got.item_kind, want.item_kind),
                 field_diff("sample_bits", got.sample_bits, want.sample_bits),
                 field_diff("sample_index", got.sample_index, want.sample_index),
                 field_diff("status", got.status, want.status),
                 field_diff("stream_ident", got.stream_ident, want.stream_ident),
                 field_diff("sequence_res", got.sequence_res, want.sequence_res),
                 field_diff("timestamp_ns", got.timestamp_ns, want.timestamp_ns),
                 field_diff("frame_total", got.frame_total, want.frame_total)};
          if (msg != "") report_mismatch(msg);
        end
      end
      if (cfg_write) begin
        if (cfg_index == CFG_MAGIC) want_magic = cfg_data;
        else want_version = cfg_data;
      end
      if (in_valid && !in_stall) take_byte(data_byte, last_byte);
    end
    pending <= exp_count;
    fail_count <= errors;
  end

endmodule

@@ dv/tb_haptics_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// tb_haptics_packet_deframer: stimulus and verdict for the packet deframer
// Sends directed and random packets, good and broken, under changing
// register settings and random idling on both channels; the checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_haptics_packet_deframer;
  import hpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAMES = MAX_FRAMES_DEF;
  localparam int CHANNELS = CHANNELS_DEF;
  localparam int FRAME_BYTES = CHANNELS * 4;
  localparam int MAX_LEN = HDR_BYTES + MAX_FRAMES * FRAME_BYTES;
  localparam int PHASE_BYTES = 150;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int PKT_DEPTH = 1024;
  localparam int PKT_AW = $clog2(PKT_DEPTH);

  typedef enum int {
    FAULT_MAGIC,
    FAULT_RESERVED,
    FAULT_COUNT,
    FAULT_VERSION,
    FAULT_ZERO_ID,
    FAULT_NO_FRAMES,
    FAULT_NONFINITE,
    FAULT_SHORT,
    FAULT_OVERLONG,
    FAULT_PARTIAL,
    FAULT_NOISE
  } fault_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_MAGIC;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        item_kind;
  logic [31:0] sample_bits;
  logic [6:0]  sample_index;
  logic [3:0]  status;
  logic [31:0] stream_ident;
  logic [63:0] sequence_res;
  logic [63:0] timestamp_ns;
  logic [15:0] frame_total;

  int pending;
  int fail_count;

  int          send_idle_pct = 26;
  int          recv_stall_pct = 58;
  bit          hold_off_req = 0;
  logic [31:0] cur_magic = '0;
  logic [31:0] cur_version = 32'd1;
  logic [7:0]  pkt [PKT_DEPTH];
  int          pkt_len = 0;

  haptics_packet_deframer #(.MAX_FRAMES(MAX_FRAMES), .CHANNELS(CHANNELS)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .item_kind(item_kind), .sample_bits(sample_bits), .sample_index(sample_index),
    .status(status), .stream_ident(stream_ident), .sequence_res(sequence_res),
    .timestamp_ns(timestamp_ns), .frame_total(frame_total)
  );

  hpd_checker #(.MAX_FRAMES(MAX_FRAMES), .CHANNELS(CHANNELS)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .item_kind(item_kind), .sample_bits(sample_bits), .sample_index(sample_index),
    .status(status), .stream_ident(stream_ident), .sequence_res(sequence_res),
    .timestamp_ns(timestamp_ns), .frame_total(frame_total),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offers one byte and returns at the edge that accepts it.
  task automatic put_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering bytes and lets every expected word arrive.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] mg, input logic [31:0] ver);
    cfg_write <= 1'b1;
    cfg_index <= CFG_MAGIC;
    cfg_data <= mg;
    @(posedge clk);
    cfg_index <= CFG_VERSION;
    cfg_data <= ver;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_magic = mg;
    cur_version = ver;
  endtask

  task automatic change_settings();
    logic [31:0] mg;
    logic [31:0] ver;
    drain_results();
    case ($urandom_range(0, 3))
      0: mg = '0;
      1: mg = '1;
      default: mg = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: ver = 32'd1;
      1: ver = '0;
      2: ver = '1;
      default: ver = $urandom;
    endcase
    write_config(mg, ver);
  endtask

  task automatic add_byte(input logic [7:0] b);
    pkt[PKT_AW'(pkt_len)] = b;
    pkt_len++;
  endtask

  // Builds a packet from the header fields and random samples, cut or padded
  // to nbytes, and sends it with the last-byte mark on its final byte.
  task automatic send_packet(input logic [31:0] mg, input logic [31:0] ver,
                             input logic [31:0] sid, input logic [63:0] sq,
                             input logic [63:0] tsv, input logic [15:0] frm,
                             input logic [15:0] rsv, input int nbytes, input int nf_pct);
    logic [31:0] w;
    pkt_len = 0;
    for (int i = 0; i < 4; i++) add_byte(mg[8*i +: 8]);
    for (int i = 0; i < 4; i++) add_byte(ver[8*i +: 8]);
    for (int i = 0; i < 4; i++) add_byte(sid[8*i +: 8]);
    for (int i = 0; i < 8; i++) add_byte(sq[8*i +: 8]);
    for (int i = 0; i < 8; i++) add_byte(tsv[8*i +: 8]);
    for (int i = 0; i < 2; i++) add_byte(frm[8*i +: 8]);
    for (int i = 0; i < 2; i++) add_byte(rsv[8*i +: 8]);
    while (pkt_len < nbytes) begin
      w = $urandom;
      if ($urandom_range(0, 99) < nf_pct) w[30:23] = 8'hFF;
      for (int j = 0; j < 4; j++) add_byte(w[8*j +: 8]);
    end
    if (pkt_len > nbytes) pkt_len = nbytes;
    for (int i = 0; i < pkt_len; i++) put_byte(pkt[PKT_AW'(i)], i == pkt_len - 1);
  endtask

  // Mostly well-formed packets with random content; the rest carry one fault or random noise.
  task automatic random_packet();
    logic [31:0] mg;
    logic [31:0] ver;
    logic [31:0] sid;
    logic [15:0] frm;
    logic [15:0] rsv;
    int          nbytes;
    int          nf_pct;
    fault_t      fault;
    mg = cur_magic;
    ver = cur_version;
    sid = $urandom;
    if (sid == '0) sid = 32'd1;
    rsv = '0;
    nf_pct = 0;
    frm = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, MAX_FRAMES))
                                        : 16'($urandom_range(1, 4));
    nbytes = HDR_BYTES + frm * FRAME_BYTES;
    if ($urandom_range(0, 99) >= 70) begin
      fault = fault_t'($urandom_range(0, FAULT_NOISE));
      case (fault)
        FAULT_MAGIC: mg = mg ^ (32'd1 << $urandom_range(0, 31));
        FAULT_RESERVED: rsv = 16'($urandom_range(1, 65535));
        FAULT_COUNT: begin
          if (frm > 1 && $urandom_range(0, 1) == 1) nbytes = nbytes - FRAME_BYTES;
          else nbytes = nbytes + FRAME_BYTES;
        end
        FAULT_VERSION: ver = ver ^ (32'd1 << $urandom_range(0, 31));
        FAULT_ZERO_ID: sid = '0;
        FAULT_NO_FRAMES: begin
          frm = '0;
          nbytes = HDR_BYTES;
        end
        FAULT_NONFINITE: nf_pct = 40;
        FAULT_SHORT: nbytes = $urandom_range(1, HDR_BYTES - 1);
        FAULT_OVERLONG: begin
          frm = 16'(MAX_FRAMES);
          nbytes = MAX_LEN + $urandom_range(1, 16);
        end
        FAULT_PARTIAL: begin
          if ($urandom_range(0, 1) == 1) nbytes = nbytes - $urandom_range(1, 3);
          else nbytes = nbytes + $urandom_range(1, 3);
        end
        default: begin
          mg = $urandom;
          ver = $urandom;
          frm = 16'($urandom);
          rsv = 16'($urandom);
          nbytes = $urandom_range(1, 80);
        end
      endcase
    end
    send_packet(mg, ver, sid, {$urandom, $urandom}, {$urandom, $urandom},
                frm, rsv, nbytes, nf_pct);
  endtask

  initial begin
    int sent;
    bit half_done;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed packets, the first under the reset register values.
    send_packet(cur_magic, cur_version, 32'd1, '0, '0, 16'd1, '0,
                HDR_BYTES + FRAME_BYTES, 0);
    drain_results();
    write_config('1, '1);
    send_packet('1, '1, '1, '1, '1, 16'd2, '0, HDR_BYTES + 2 * FRAME_BYTES, 0);
    send_packet('1, '1, 32'd5, '0, '0, 16'd1, '0, 1, 0);
    send_packet('1, '1, 32'd5, '0, '0, 16'd1, '0, HDR_BYTES - 1, 0);
    send_packet(32'h7FFF_FFFF, '1, 32'd5, 64'd1, 64'd2, 16'd1, '0,
                HDR_BYTES + FRAME_BYTES, 0);
    send_packet('1, '1, 32'd5, 64'd3, 64'd4, 16'd1, 16'hFFFF,
                HDR_BYTES + FRAME_BYTES, 0);
    send_packet('1, '1, 32'd5, 64'd5, 64'd6, 16'd2, '0, HDR_BYTES + FRAME_BYTES, 0);
    send_packet('1, '0, 32'd5, 64'd7, 64'd8, 16'd1, '0, HDR_BYTES + FRAME_BYTES, 0);
    send_packet('1, '1, '0, 64'd9, 64'd10, 16'd1, '0, HDR_BYTES + FRAME_BYTES, 0);
    send_packet('1, '1, 32'd5, 64'd11, 64'd12, '0, '0, HDR_BYTES, 0);
    send_packet('1, '1, 32'd5, 64'd13, 64'd14, 16'd1, '0, HDR_BYTES + FRAME_BYTES, 100);
    // A packet ending in the middle of a sample.
    send_packet('1, '1, 32'd5, 64'd15, 64'd16, 16'd1, '0,
                HDR_BYTES + FRAME_BYTES + 2, 0);
    // A packet longer than the longest legal one, then a frame count too large.
    send_packet('1, '1, 32'd7, '0, '1, 16'(MAX_FRAMES), '0, MAX_LEN + 5, 0);
    send_packet('1, '1, 32'd7, 64'd17, 64'd18, 16'(MAX_FRAMES + 1), '0,
                HDR_BYTES + FRAME_BYTES, 0);
    drain_results();
    write_config('0, '0);
    send_packet('0, '0, 32'h8000_0000, 64'h8000_0000_0000_0000, 64'd19, 16'd3, '0,
                HDR_BYTES + 3 * FRAME_BYTES, 0);
    send_packet('0, '0, 32'd9, 64'd20, 64'd21, 16'd1, '0, HDR_BYTES, 0);

    // Random packets under three idling patterns.
    for (int p = 0; p < 3; p++) begin
      change_settings();
      case (p)
        0: begin
          send_idle_pct = 26;
          recv_stall_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_stall_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      // The receiver holds off while the sender keeps offering bytes.
      if (p == 0) hold_off_req = 1;
      sent = 0;
      half_done = 0;
      while (sent < PHASE_BYTES) begin
        if (!half_done && sent >= PHASE_BYTES / 2) begin
          change_settings();
          half_done = 1;
        end
        random_packet();
        sent += pkt_len;
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hpd_pkg.sv
rtl/haptics_packet_deframer.sv
dv/hpd_checker.sv
dv/tb_haptics_packet_deframer.sv
